// ===== rtl/ffa_pkg.sv =====
// shared constants, command codes and control/status types of the first-fit allocator
`timescale 1ns / 1ps
package ffa_pkg;

	localparam int HEAP_UNITS = 4096;
	localparam int ADDR_W     = $clog2(HEAP_UNITS);
	localparam int IDX_W      = ADDR_W + 1;
	localparam int UNITS_W    = IDX_W + 1;
	localparam int OFS_W      = 15;
	localparam int NBYTES_W   = 16;

	localparam logic [IDX_W-1:0]   SENT       = IDX_W'(HEAP_UNITS);
	localparam logic [IDX_W-1:0]   WALK_LIMIT = IDX_W'(HEAP_UNITS + 2);
	localparam logic [UNITS_W-1:0] HEAP_TOP   = UNITS_W'(HEAP_UNITS);

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FAIL = 2'd1;
	localparam logic [1:0] ST_IGN  = 2'd2;

	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
	localparam logic [OP_W-1:0] OP_FAIL     = 5'd2;
	localparam logic [OP_W-1:0] OP_IGN      = 5'd3;
	localparam logic [OP_W-1:0] OP_RD_P     = 5'd4;
	localparam logic [OP_W-1:0] OP_ADV      = 5'd5;
	localparam logic [OP_W-1:0] OP_A_SPLIT1 = 5'd6;
	localparam logic [OP_W-1:0] OP_A_SPLIT2 = 5'd7;
	localparam logic [OP_W-1:0] OP_A_EXACT  = 5'd8;
	localparam logic [OP_W-1:0] OP_BRK      = 5'd9;
	localparam logic [OP_W-1:0] OP_F_RD1    = 5'd10;
	localparam logic [OP_W-1:0] OP_F_CAP1   = 5'd11;
	localparam logic [OP_W-1:0] OP_F_CAP2   = 5'd12;
	localparam logic [OP_W-1:0] OP_F_A1     = 5'd13;
	localparam logic [OP_W-1:0] OP_F_A2     = 5'd14;
	localparam logic [OP_W-1:0] OP_F_RD2    = 5'd15;
	localparam logic [OP_W-1:0] OP_F_CAP3   = 5'd16;
	localparam logic [OP_W-1:0] OP_F_B      = 5'd17;
	localparam logic [OP_W-1:0] OP_F_I1     = 5'd18;
	localparam logic [OP_W-1:0] OP_F_I2     = 5'd19;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            out_load;
	} ffa_cmd_t;

	typedef struct packed {
		logic is_free;
		logic nbytes_zero;
		logic bp_oob;
		logic p_sent;
		logic walk_lim;
		logic p_gt_bp;
		logic fit_gt;
		logic fit_eq;
		logic brk_ok;
		logic cond_a;
		logic cond_b;
		logic a_done;
	} ffa_stat_t;

	// byte offset of the user area behind header unit u
	function automatic logic [OFS_W-1:0] user_of(input logic [ADDR_W-1:0] u);
		logic [ADDR_W-1:0] n;
		n = u + ADDR_W'(1);
		return {n, 3'b000};
	endfunction

endpackage

// ===== rtl/ffa_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/ffa_datapath.sv =====
// allocator datapath: list pointers, header memories, break pointer and result registers
`timescale 1ns / 1ps
module ffa_datapath import ffa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  ffa_cmd_t            cmd,
	output ffa_stat_t           stat,
	input  logic                kind,
	input  logic [NBYTES_W-1:0] nbytes,
	input  logic [OFS_W-1:0]    block_offset,
	output logic [OFS_W-1:0]    user_offset,
	output logic [1:0]          status
);

	logic               kind_q, nbz_q, uz_q, a_q;
	logic [UNITS_W-1:0] units_q, q_q;
	logic [IDX_W-1:0]   bp_q, p_q, prev_q, steps_q, brk_q, sent_next_q;
	logic [IDX_W-1:0]   bsz_q, szp_q, nxp_q, szprev_q, nxbp_q;
	logic [IDX_W-1:0]   nrd_idx_q, srd_idx_q;
	logic [OFS_W-1:0]   res_ofs_q, user_offset_q;
	logic [1:0]         res_st_q, status_q;

	logic               n_re, s_re, nwr_en, swr_en;
	logic [IDX_W-1:0]   n_ridx, s_ridx, nwr_idx, nwr_data, swr_idx, swr_data;
	logic [IDX_W-1:0]   n_rdata, s_rdata, next_val, size_val, sz_rem;
	logic [ADDR_W-1:0]  unit_in;

	// links and sizes outside the store read as the sentinel and as zero
	assign next_val = (nrd_idx_q == SENT) ? sent_next_q :
		(nrd_idx_q > SENT) ? SENT : n_rdata;
	assign size_val = nrd_idx_q[IDX_W-1] == 1'b0 || srd_idx_q[IDX_W-1] == 1'b0 ?
		(srd_idx_q[IDX_W-1] ? '0 : s_rdata) : '0;
	assign sz_rem   = size_val - units_q[IDX_W-1:0];
	assign unit_in  = block_offset[OFS_W-1:3];

	always_comb begin
		n_re     = 1'b0;
		s_re     = 1'b0;
		n_ridx   = p_q;
		s_ridx   = p_q;
		nwr_en   = 1'b0;
		nwr_idx  = prev_q;
		nwr_data = bp_q;
		swr_en   = 1'b0;
		swr_idx  = p_q;
		swr_data = sz_rem;
		unique case (cmd.op)
			OP_RD_P: begin
				n_re = 1'b1;
				s_re = 1'b1;
			end
			OP_A_SPLIT1: begin
				swr_en = 1'b1;
			end
			OP_A_SPLIT2: begin
				swr_en   = q_q < HEAP_TOP;
				swr_idx  = q_q[IDX_W-1:0];
				swr_data = units_q[IDX_W-1:0];
			end
			OP_A_EXACT: begin
				nwr_en   = 1'b1;
				nwr_data = next_val;
			end
			OP_BRK: begin
				nwr_en   = 1'b1;
				nwr_idx  = brk_q;
				nwr_data = '0;
				swr_en   = 1'b1;
				swr_idx  = brk_q;
				swr_data = units_q[IDX_W-1:0];
			end
			OP_F_RD1: begin
				s_re   = 1'b1;
				s_ridx = bp_q;
				n_re   = 1'b1;
			end
			OP_F_CAP1: begin
				s_re = 1'b1;
			end
			OP_F_A1: begin
				swr_en   = 1'b1;
				swr_idx  = bp_q;
				swr_data = bsz_q + szp_q;
				nwr_en   = 1'b1;
				nwr_idx  = bp_q;
				nwr_data = nxp_q;
			end
			OP_F_A2, OP_F_I1: begin
				nwr_en = 1'b1;
			end
			OP_F_RD2: begin
				s_re   = 1'b1;
				s_ridx = prev_q;
				n_re   = 1'b1;
				n_ridx = bp_q;
			end
			OP_F_CAP3: begin
				s_re   = 1'b1;
				s_ridx = bp_q;
			end
			OP_F_B: begin
				swr_en   = 1'b1;
				swr_idx  = prev_q;
				swr_data = szprev_q + size_val;
				nwr_en   = a_q;
				nwr_data = nxbp_q;
			end
			OP_F_I2: begin
				nwr_en   = 1'b1;
				nwr_idx  = bp_q;
				nwr_data = p_q;
			end
			default: begin
			end
		endcase
	end

	ffa_ram #(.WIDTH(IDX_W), .DEPTH(HEAP_UNITS)) u_next_ram (
		.clk   (clk),
		.we    (nwr_en & ~nwr_idx[IDX_W-1]),
		.waddr (nwr_idx[ADDR_W-1:0]),
		.wdata (nwr_data),
		.re    (n_re),
		.raddr (n_ridx[ADDR_W-1:0]),
		.rdata (n_rdata)
	);

	ffa_ram #(.WIDTH(IDX_W), .DEPTH(HEAP_UNITS)) u_size_ram (
		.clk   (clk),
		.we    (swr_en & ~swr_idx[IDX_W-1]),
		.waddr (swr_idx[ADDR_W-1:0]),
		.wdata (swr_data),
		.re    (s_re),
		.raddr (s_ridx[ADDR_W-1:0]),
		.rdata (s_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brk_q       <= '0;
			sent_next_q <= SENT;
			steps_q     <= '0;
		end else begin
			if (nwr_en && nwr_idx == SENT) begin
				sent_next_q <= nwr_data;
			end
			if (cmd.op == OP_BRK) begin
				brk_q <= brk_q + units_q[IDX_W-1:0];
			end
			if (cmd.op == OP_LOAD) begin
				steps_q <= '0;
			end else if (cmd.op == OP_ADV) begin
				steps_q <= steps_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (n_re) begin
			nrd_idx_q <= n_ridx;
		end
		if (s_re) begin
			srd_idx_q <= s_ridx;
		end
		unique case (cmd.op)
			OP_LOAD: begin
				kind_q    <= kind;
				nbz_q     <= nbytes == '0;
				units_q   <= UNITS_W'(((nbytes - NBYTES_W'(1)) >> 3)) + UNITS_W'(2);
				uz_q      <= unit_in == '0;
				bp_q      <= {1'b0, unit_in - ADDR_W'(1)};
				prev_q    <= SENT;
				p_q       <= sent_next_q;
				a_q       <= 1'b0;
				res_ofs_q <= '0;
				res_st_q  <= ST_OK;
			end
			OP_FAIL:     res_st_q  <= ST_FAIL;
			OP_IGN:      res_st_q  <= ST_IGN;
			OP_ADV: begin
				prev_q <= p_q;
				p_q    <= next_val;
			end
			OP_A_SPLIT1: q_q       <= {1'b0, p_q} + {1'b0, sz_rem};
			OP_A_SPLIT2: res_ofs_q <= user_of(q_q[ADDR_W-1:0]);
			OP_A_EXACT:  res_ofs_q <= user_of(p_q[ADDR_W-1:0]);
			OP_BRK:      res_ofs_q <= user_of(brk_q[ADDR_W-1:0]);
			OP_F_CAP1: begin
				bsz_q <= size_val;
				nxp_q <= next_val;
			end
			OP_F_CAP2:   szp_q     <= size_val;
			OP_F_A1:     a_q       <= 1'b1;
			OP_F_CAP3: begin
				szprev_q <= size_val;
				nxbp_q   <= next_val;
			end
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			user_offset_q <= res_ofs_q;
			status_q      <= res_st_q;
		end
	end

	always_comb begin
		stat.is_free     = kind_q == KIND_FREE;
		stat.nbytes_zero = nbz_q;
		stat.bp_oob      = uz_q || (bp_q >= brk_q);
		stat.p_sent      = p_q == SENT;
		stat.walk_lim    = steps_q >= WALK_LIMIT;
		stat.p_gt_bp     = p_q > bp_q;
		stat.fit_gt      = {1'b0, size_val} > units_q;
		stat.fit_eq      = {1'b0, size_val} == units_q;
		stat.brk_ok      = ({1'b0, brk_q} + units_q) < HEAP_TOP;
		stat.cond_a      = (p_q != SENT) && (({1'b0, bp_q} + {1'b0, bsz_q}) == {1'b0, p_q});
		stat.cond_b      = (prev_q != SENT) &&
			(({1'b0, prev_q} + {1'b0, szprev_q}) == {1'b0, bp_q});
		stat.a_done      = a_q;
	end

	assign user_offset = user_offset_q;
	assign status      = status_q;

	// break never passes the top of the store, walk counter stops at its limit
	a_brk_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		brk_q < SENT) else $error("break pointer left the store");
	a_steps_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= WALK_LIMIT) else $error("list walk ran past its limit");
	a_brk_grows_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_BRK |-> stat.brk_ok) else $error("break grown without room");

endmodule

// ===== rtl/ffa_ctrl.sv =====
// allocator controller: request sequencing and output handshake
`timescale 1ns / 1ps
module ffa_ctrl import ffa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  ffa_stat_t stat,
	output ffa_cmd_t  cmd
);

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_START    = 5'd1;
	localparam logic [4:0] S_A_WALK   = 5'd2;
	localparam logic [4:0] S_A_EVAL   = 5'd3;
	localparam logic [4:0] S_A_SPLIT2 = 5'd4;
	localparam logic [4:0] S_A_BRK    = 5'd5;
	localparam logic [4:0] S_F_WALK   = 5'd6;
	localparam logic [4:0] S_F_ADV    = 5'd7;
	localparam logic [4:0] S_F_CAP1   = 5'd8;
	localparam logic [4:0] S_F_CAP2   = 5'd9;
	localparam logic [4:0] S_F_DECA   = 5'd10;
	localparam logic [4:0] S_F_A2     = 5'd11;
	localparam logic [4:0] S_F_RD2    = 5'd12;
	localparam logic [4:0] S_F_CAP3   = 5'd13;
	localparam logic [4:0] S_F_FIN    = 5'd14;
	localparam logic [4:0] S_F_I2     = 5'd15;
	localparam logic [4:0] S_DONE     = 5'd16;

	logic [4:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d      = state_q;
		cmd.op       = OP_NONE;
		cmd.out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_START;
				end
			end
			S_START: begin
				if (!stat.is_free) begin
					if (stat.nbytes_zero) begin
						cmd.op  = OP_FAIL;
						state_d = S_DONE;
					end else begin
						state_d = S_A_WALK;
					end
				end else if (stat.bp_oob) begin
					cmd.op  = OP_IGN;
					state_d = S_DONE;
				end else begin
					state_d = S_F_WALK;
				end
			end
			S_A_WALK: begin
				if (stat.p_sent || stat.walk_lim) begin
					state_d = S_A_BRK;
				end else begin
					cmd.op  = OP_RD_P;
					state_d = S_A_EVAL;
				end
			end
			S_A_EVAL: begin
				priority if (stat.fit_gt) begin
					cmd.op  = OP_A_SPLIT1;
					state_d = S_A_SPLIT2;
				end else if (stat.fit_eq) begin
					cmd.op  = OP_A_EXACT;
					state_d = S_DONE;
				end else begin
					cmd.op  = OP_ADV;
					state_d = S_A_WALK;
				end
			end
			S_A_SPLIT2: begin
				cmd.op  = OP_A_SPLIT2;
				state_d = S_DONE;
			end
			S_A_BRK: begin
				cmd.op  = stat.brk_ok ? OP_BRK : OP_FAIL;
				state_d = S_DONE;
			end
			S_F_WALK: begin
				if (stat.p_sent || stat.walk_lim || stat.p_gt_bp) begin
					cmd.op  = OP_F_RD1;
					state_d = S_F_CAP1;
				end else begin
					cmd.op  = OP_RD_P;
					state_d = S_F_ADV;
				end
			end
			S_F_ADV: begin
				cmd.op  = OP_ADV;
				state_d = S_F_WALK;
			end
			S_F_CAP1: begin
				cmd.op  = OP_F_CAP1;
				state_d = S_F_CAP2;
			end
			S_F_CAP2: begin
				cmd.op  = OP_F_CAP2;
				state_d = S_F_DECA;
			end
			S_F_DECA: begin
				// merge with the following block first
				if (stat.cond_a) begin
					cmd.op  = OP_F_A1;
					state_d = S_F_A2;
				end else begin
					cmd.op  = OP_F_RD2;
					state_d = S_F_CAP3;
				end
			end
			S_F_A2: begin
				cmd.op  = OP_F_A2;
				state_d = S_F_RD2;
			end
			S_F_RD2: begin
				cmd.op  = OP_F_RD2;
				state_d = S_F_CAP3;
			end
			S_F_CAP3: begin
				cmd.op  = OP_F_CAP3;
				state_d = S_F_FIN;
			end
			S_F_FIN: begin
				priority if (stat.cond_b) begin
					cmd.op  = OP_F_B;
					state_d = S_DONE;
				end else if (!stat.a_done) begin
					cmd.op  = OP_F_I1;
					state_d = S_F_I2;
				end else begin
					state_d = S_DONE;
				end
			end
			S_F_I2: begin
				cmd.op  = OP_F_I2;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free) else $error("result overwritten while stalled");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == S_START) else $error("item accepted but not started");
	a_load_then_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q) else $error("result loaded but not shown");
	a_free_ops_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_F_RD1) |-> stat.is_free) else $error("free sequence on allocate item");

endmodule

// ===== rtl/first_fit_free_list_allocator.sv =====
// top level of the first-fit free-list heap allocator
`timescale 1ns / 1ps
// Heap allocator over 4096 header units of 8 bytes, with an address-ordered
// free list kept in two header memories (next link, size).
// Input channel: in_valid/in_stall with kind, nbytes, block_offset. An item
// is taken when in_valid is high and in_stall low; in_stall is high while a
// request is being worked on.
// Output channel: out_valid/out_stall with user_offset and status, held in an
// output register, so a new item is taken while a result is still stalled.
// An allocate walks the free list node by node, then splits a block, takes
// it whole, grows the break or fails; a free walks the nodes ahead of the
// block, then merges it with its neighbours or links it in; a zero-byte
// allocate or an out-of-range free skips the walk. One item at a time; the
// walk reads one node at a time through the one read port of each header
// memory. A stalled result holds the next one in its done state.
// Reset: the free list is empty (sentinel links to itself), the break pointer
// is zero, no result is pending. Header memories are not cleared; every entry
// is written before a legal request reads it.
module first_fit_free_list_allocator import ffa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	input  logic [NBYTES_W-1:0] nbytes,
	input  logic [OFS_W-1:0]    block_offset,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [OFS_W-1:0]    user_offset,
	output logic [1:0]          status
);

	ffa_cmd_t  cmd;
	ffa_stat_t stat;

	ffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	ffa_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.kind         (kind),
		.nbytes       (nbytes),
		.block_offset (block_offset),
		.user_offset  (user_offset),
		.status       (status)
	);

endmodule

// ===== verif/first_fit_free_list_allocator_tb.sv =====
// self-checking testbench for the first-fit free-list heap allocator
`timescale 1ns / 1ps
module first_fit_free_list_allocator_tb;
	import ffa_pkg::*;

	localparam int HEAP_WALK = HEAP_UNITS + 2;
	localparam int STALL_LIMIT = 60000;

	typedef struct {
		logic [OFS_W-1:0] ofs;
		logic [1:0]       st;
	} heap_result_t;

	typedef struct {
		logic                kind;
		logic [NBYTES_W-1:0] nbytes;
		logic [OFS_W-1:0]    ofs;
		bit                  fixed;
		logic [OFS_W-1:0]    e_ofs;
		logic [1:0]          e_st;
	} req_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                kind;
	logic [NBYTES_W-1:0] nbytes;
	logic [OFS_W-1:0]    block_offset;
	logic                out_valid;
	logic                out_stall;
	logic [OFS_W-1:0]    user_offset;
	logic [1:0]          status;

	first_fit_free_list_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .nbytes(nbytes), .block_offset(block_offset),
		.out_valid(out_valid), .out_stall(out_stall),
		.user_offset(user_offset), .status(status)
	);

	// shadow heap: per unit link and size, sentinel link, break pointer
	int unsigned hdr_next[HEAP_UNITS];
	int unsigned hdr_size[HEAP_UNITS];
	int unsigned sent_link;
	int unsigned brk_unit;
	logic [OFS_W-1:0] live_blocks[$];
	heap_result_t pending_results[$];

	int errors;
	int n_alloc_ok, n_alloc_fail, n_free_ok, n_free_ign, n_results;
	int idle_pct, stall_pct;
	int quiet_cycles;

	req_row_t dir_rows[] = '{
		'{KIND_FREE,  16'd0,     15'd0,     1'b1, 15'd0,  ST_IGN},   // free before any allocate
		'{KIND_ALLOC, 16'd0,     15'd0,     1'b1, 15'd0,  ST_FAIL},
		'{KIND_ALLOC, 16'd65535, 15'd0,     1'b1, 15'd0,  ST_FAIL},
		'{KIND_ALLOC, 16'd1,     15'd0,     1'b1, 15'd8,  ST_OK},
		'{KIND_ALLOC, 16'd8,     15'd0,     1'b1, 15'd24, ST_OK},
		'{KIND_ALLOC, 16'd9,     15'd0,     1'b1, 15'd40, ST_OK},
		'{KIND_FREE,  16'd0,     15'd32767, 1'b1, 15'd0,  ST_IGN},
		'{KIND_FREE,  16'd0,     15'd7,     1'b1, 15'd0,  ST_IGN},
		'{KIND_FREE,  16'd0,     15'd64,    1'b1, 15'd0,  ST_IGN},   // header at break
		'{KIND_FREE,  16'd0,     15'd8,     1'b0, 15'd0,  ST_OK},
		'{KIND_FREE,  16'd0,     15'd47,    1'b0, 15'd0,  ST_OK},    // low bits ignored
		'{KIND_FREE,  16'd0,     15'd24,    1'b0, 15'd0,  ST_OK},    // merges both sides
		'{KIND_ALLOC, 16'd16,    15'd0,     1'b0, 15'd0,  ST_OK},    // split from tail
		'{KIND_ALLOC, 16'd17,    15'd0,     1'b0, 15'd0,  ST_OK},    // exact fit
		'{KIND_ALLOC, 16'd1000,  15'd0,     1'b0, 15'd0,  ST_OK},
		'{KIND_ALLOC, 16'd32767, 15'd0,     1'b1, 15'd0,  ST_FAIL},
		'{KIND_ALLOC, 16'd65534, 15'd0,     1'b1, 15'd0,  ST_FAIL}
	};

	function automatic int unsigned link_of(int unsigned i);
		if (i == HEAP_UNITS)
			return sent_link;
		if (i < HEAP_UNITS)
			return hdr_next[i];
		return HEAP_UNITS;
	endfunction

	function automatic int unsigned size_of(int unsigned i);
		return (i < HEAP_UNITS) ? hdr_size[i] : 0;
	endfunction

	function automatic void set_link(int unsigned i, int unsigned v);
		if (i == HEAP_UNITS)
			sent_link = v;
		else if (i < HEAP_UNITS)
			hdr_next[i] = v;
	endfunction

	function automatic void set_size(int unsigned i, int unsigned v);
		if (i < HEAP_UNITS)
			hdr_size[i] = v;
	endfunction

	function automatic logic [OFS_W-1:0] user_area(int unsigned u);
		return OFS_W'((u + 1) * 8);
	endfunction

	function automatic heap_result_t heap_alloc(int unsigned nb);
		heap_result_t r;
		int unsigned units, prev, p, sz, q, steps;
		r.ofs = '0;
		r.st = ST_FAIL;
		if (nb == 0)
			return r;
		units = (nb - 1) / 8 + 2;
		prev = HEAP_UNITS;
		p = link_of(HEAP_UNITS);
		steps = 0;
		while (p != HEAP_UNITS && steps < HEAP_WALK) begin
			sz = size_of(p);
			if (sz > units) begin
				sz -= units;
				set_size(p, sz);
				q = p + sz;
				set_size(q, units);
				r.ofs = user_area(q);
				r.st = ST_OK;
				return r;
			end
			if (sz == units) begin
				set_link(prev, link_of(p));
				r.ofs = user_area(p);
				r.st = ST_OK;
				return r;
			end
			prev = p;
			p = link_of(p);
			steps++;
		end
		if (brk_unit + units < HEAP_UNITS) begin
			q = brk_unit;
			brk_unit += units;
			set_link(q, 0);
			set_size(q, units);
			r.ofs = user_area(q);
			r.st = ST_OK;
		end
		return r;
	endfunction

	function automatic heap_result_t heap_free(int unsigned ofs);
		heap_result_t r;
		int unsigned unit, bp, prev, p, steps, bsz;
		bit linked;
		r.ofs = '0;
		r.st = ST_IGN;
		unit = ofs / 8;
		if (unit == 0)
			return r;
		bp = unit - 1;
		if (bp >= brk_unit)
			return r;
		r.st = ST_OK;
		linked = 1'b1;
		prev = HEAP_UNITS;
		p = link_of(HEAP_UNITS);
		steps = 0;
		while (p != HEAP_UNITS && steps < HEAP_WALK) begin
			if (p > bp)
				break;
			prev = p;
			p = link_of(p);
			steps++;
		end
		bsz = size_of(bp);
		if (p != HEAP_UNITS && bp + bsz == p) begin
			set_size(bp, bsz + size_of(p));
			set_link(bp, link_of(p));
			set_link(prev, bp);
			linked = 1'b0;
		end
		if (prev != HEAP_UNITS && prev + size_of(prev) == bp) begin
			set_size(prev, size_of(prev) + size_of(bp));
			if (!linked)
				set_link(prev, link_of(bp));
			linked = 1'b0;
		end
		if (linked) begin
			set_link(prev, bp);
			set_link(bp, p);
		end
		return r;
	endfunction

	// predicts one request and keeps the list of live user areas current
	function automatic heap_result_t predict_request(logic k, int unsigned nb, int unsigned ofs);
		heap_result_t r;
		if (k == KIND_ALLOC) begin
			r = heap_alloc(nb);
			if (r.st == ST_OK) begin
				live_blocks.push_back(r.ofs);
				n_alloc_ok++;
			end else begin
				n_alloc_fail++;
			end
		end else begin
			r = heap_free(ofs);
			if (r.st == ST_OK) begin
				n_free_ok++;
				foreach (live_blocks[i])
					if (live_blocks[i] == OFS_W'(ofs & 32'h7ff8)) begin
						live_blocks.delete(i);
						break;
					end
			end else begin
				n_free_ign++;
			end
		end
		return r;
	endfunction

	task automatic send_request(logic k, logic [NBYTES_W-1:0] nb, logic [OFS_W-1:0] ofs,
			heap_result_t r);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		kind <= k;
		nbytes <= nb;
		block_offset <= ofs;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.push_back(r);
		@(negedge clk);
	endtask

	task automatic random_request(int alloc_pct);
		logic k;
		logic [NBYTES_W-1:0] nb;
		logic [OFS_W-1:0] ofs;
		int unsigned pick, lo;
		heap_result_t r;
		k = (live_blocks.size() == 0 || $urandom_range(99) < alloc_pct) ? KIND_ALLOC : KIND_FREE;
		nb = NBYTES_W'($urandom);
		ofs = OFS_W'($urandom);
		if (k == KIND_ALLOC) begin
			pick = $urandom_range(99);
			if (pick < 80)
				nb = NBYTES_W'($urandom_range(1, 64));
			else if (pick < 94)
				nb = NBYTES_W'($urandom_range(1, 2000));
			else if (pick < 97)
				nb = '0;
		end else if ($urandom_range(99) < 88) begin
			ofs = live_blocks[$urandom_range(live_blocks.size() - 1)] | OFS_W'($urandom_range(7));
		end else begin
			// out of range: header below zero or at or past the break
			lo = (brk_unit + 1) * 8;
			if ($urandom_range(1) == 0 || lo > 32767)
				ofs = OFS_W'($urandom_range(7));
			else
				ofs = OFS_W'($urandom_range(32767, lo));
		end
		r = predict_request(k, nb, ofs);
		send_request(k, nb, ofs, r);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		heap_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result ofs=%0d status=%0d", $time, user_offset, status);
			end else begin
				e = pending_results.pop_front();
				if (user_offset !== e.ofs) begin
					errors++;
					$display("%0t: user_offset expected %0d actual %0d", $time, e.ofs, user_offset);
				end
				if (status !== e.st) begin
					errors++;
					$display("%0t: status expected %0d actual %0d", $time, e.st, status);
				end
			end
		end
	end

	// watchdog on cycles with no item taken on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
			$display("first_fit_free_list_allocator test failed");
			$finish;
		end
	end

	initial begin
		heap_result_t r;
		int wait_cnt;
		in_valid = 1'b0;
		kind = KIND_ALLOC;
		nbytes = '0;
		block_offset = '0;
		out_stall = 1'b0;
		errors = 0;
		quiet_cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		n_alloc_ok = 0; n_alloc_fail = 0; n_free_ok = 0; n_free_ign = 0; n_results = 0;
		foreach (hdr_next[i]) begin
			hdr_next[i] = 0;
			hdr_size[i] = 0;
		end
		sent_link = HEAP_UNITS;
		brk_unit = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			r = predict_request(dir_rows[i].kind, dir_rows[i].nbytes, dir_rows[i].ofs);
			if (dir_rows[i].fixed) begin
				r.ofs = dir_rows[i].e_ofs;
				r.st = dir_rows[i].e_st;
			end
			send_request(dir_rows[i].kind, dir_rows[i].nbytes, dir_rows[i].ofs, r);
		end

		// idle and output-stall phases; allocate-heavy stretches push the heap to full
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 60; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 60; end
				default: begin idle_pct = 9; stall_pct = 9; end
			endcase
			for (int n = 0; n < 222; n++)
				random_request((n / 111) % 2 ? 40 : 75);
			if (ph == 3) begin
				in_valid <= 1'b0;
				while (pending_results.size() != 0)
					@(negedge clk);
			end
		end

		in_valid <= 1'b0;
		wait_cnt = 0;
		while (pending_results.size() != 0 && wait_cnt < STALL_LIMIT) begin
			@(posedge clk);
			wait_cnt++;
		end
		stall_pct = 0;
		repeat (40) @(posedge clk);
		$display("covered %0d allocations (%0d failed) and %0d frees (%0d ignored), %0d results",
			n_alloc_ok + n_alloc_fail, n_alloc_fail, n_free_ok + n_free_ign, n_free_ign,
			n_results);
		if (errors == 0 && pending_results.size() == 0)
			$display("first_fit_free_list_allocator test passed");
		else
			$display("first_fit_free_list_allocator test failed");
		$finish;
	end

endmodule
